[rtl/irpsc_pkg.sv]
// ----------------------------------------------------------------------------
// irpsc_pkg - shared types and constants for the IR pulse period sync checker
// Widths, register indexes, configuration bundle and the margin compare.
// ----------------------------------------------------------------------------
package irpsc_pkg;

  localparam int unsigned StampBits     = 24;
  localparam int unsigned PulsesForSync = 4;
  localparam int unsigned NumIntervals  = PulsesForSync - 1;
  localparam int unsigned NumPeriods    = 4;
  localparam int unsigned IdxBits       = $clog2(NumIntervals);
  localparam int unsigned CntBits       = $clog2(PulsesForSync + 1);
  localparam int unsigned CfgIdxBits    = 3;

  typedef logic [StampBits-1:0] stamp_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    RegIntervalMargin = 3'd0,
    RegPeriodMargin   = 3'd1,
    RegPeriodA        = 3'd2,
    RegPeriodB        = 3'd3,
    RegPeriodC        = 3'd4,
    RegPeriodD        = 3'd5
  } cfg_reg_e;

  // Input event modes
  typedef enum logic {
    ModePulse  = 1'b0,
    ModeMissed = 1'b1
  } mode_e;

  typedef struct packed {
    stamp_t                         interval_margin;
    stamp_t                         period_margin;
    logic [NumPeriods-1:0][StampBits-1:0] periods;
  } cfg_t;

  typedef struct packed {
    logic   evaluated;
    logic   locked;
    stamp_t sync_period;
    logic   hunting;
  } res_t;

  // True when value lies within margin of ref_val; the lower bound clamps at
  // zero, so this is simply |value - ref_val| <= margin.
  function automatic logic within_margin(stamp_t value, stamp_t ref_val, stamp_t margin);
    stamp_t diff;
    diff = (value >= ref_val) ? (value - ref_val) : (ref_val - value);
    return (diff <= margin);
  endfunction

endpackage

[rtl/irpsc_if.sv]
// ----------------------------------------------------------------------------
// irpsc_if - valid/ready channels of the IR pulse period sync checker
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface irpsc_in_if import irpsc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   mode;
  stamp_t stamp;

  modport source (output valid, output mode, output stamp, input ready);
  modport sink   (input valid, input mode, input stamp, output ready);
endinterface

interface irpsc_out_if import irpsc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   evaluated;
  logic   locked;
  stamp_t sync_period;
  logic   hunting;

  modport source (output valid, output evaluated, output locked, output sync_period,
                  output hunting, input ready);
  modport sink   (input valid, input evaluated, input locked, input sync_period,
                  input hunting, output ready);
endinterface

interface irpsc_cfg_if import irpsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  stamp_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/irpsc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// irpsc_cfg_regs - configuration register file
// Holds the margins and the four expected periods; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module irpsc_cfg_regs import irpsc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  irpsc_cfg_if.sink      cfg_i,
  output cfg_t           cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Always take a write transfer
  assign cfg_i.ready = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        RegIntervalMargin: cfg_d.interval_margin = cfg_i.data;
        RegPeriodMargin:   cfg_d.period_margin   = cfg_i.data;
        RegPeriodA:        cfg_d.periods[0]      = cfg_i.data;
        RegPeriodB:        cfg_d.periods[1]      = cfg_i.data;
        RegPeriodC:        cfg_d.periods[2]      = cfg_i.data;
        RegPeriodD:        cfg_d.periods[3]      = cfg_i.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_margin <= StampBits'(65);
      cfg_q.period_margin   <= StampBits'(32);
      cfg_q.periods[0]      <= StampBits'(163);
      cfg_q.periods[1]      <= StampBits'(819);
      cfg_q.periods[2]      <= StampBits'(1638);
      cfg_q.periods[3]      <= StampBits'(3276);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ir_pulse_period_sync_checker.sv]
// ----------------------------------------------------------------------------
// ir_pulse_period_sync_checker - IR pulse period sync checker, top level
// Collects pulse timestamps while hunting and checks the measured intervals
// against each other and against four expected periods.
// ----------------------------------------------------------------------------
// One event is taken every clock cycle while the result channel is not
// stalled. Each event lands in an input register; from there it passes
// through the sequencing and compare logic (one interval subtract, two
// interval margin checks and four period margin checks in parallel) into
// the result register, from which the result is offered. A result that
// waits to be taken holds the event in the input register; an empty input
// register still lets the next event in while a result waits to be taken.
// Configuration writes are taken in every cycle and must only be issued
// while the block is idle.
module ir_pulse_period_sync_checker import irpsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  irpsc_in_if.sink    in_i,
  irpsc_out_if.source out_o,
  irpsc_cfg_if.sink   cfg_i
);

  cfg_t cfg;

  irpsc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register
  logic   in_valid_q;
  logic   mode_q;
  stamp_t stamp_q;

  // Result register
  logic   out_valid_q;
  res_t   out_q;
  res_t   res_d;

  // Hunting state
  logic                  hunt_q, hunt_d;
  logic [CntBits-1:0]    pulses_left_q, pulses_left_d;
  stamp_t                last_stamp_q, last_stamp_d;
  logic [NumIntervals-1:0][StampBits-1:0] intervals_q, intervals_d;
  logic [IdxBits-1:0]    slot;
  logic                  period_hit;
  logic                  lock_ok;
  logic                  advance;

  // Move the held event on when the result slot is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q  <= in_i.mode;
      stamp_q <= in_i.stamp;
    end
  end

  // Interval slot follows from the pulse count
  assign slot = IdxBits'(CntBits'(NumIntervals) - pulses_left_q);

  // Evaluation compares
  always_comb begin
    period_hit = 1'b0;
    for (int i = 0; i < NumPeriods; i++) begin
      period_hit = period_hit |
                   within_margin(intervals_q[1], cfg.periods[i], cfg.period_margin);
    end
    lock_ok = within_margin(intervals_q[1], intervals_q[0], cfg.interval_margin) &&
              within_margin(intervals_q[2], intervals_q[1], cfg.interval_margin) &&
              period_hit;
  end

  // Sequence the hunt and build the result
  always_comb begin
    hunt_d         = hunt_q;
    pulses_left_d  = pulses_left_q;
    last_stamp_d   = last_stamp_q;
    intervals_d    = intervals_q;
    res_d          = '0;
    if (mode_e'(mode_q) == ModeMissed) begin
      hunt_d = 1'b1;
    end else if (hunt_q) begin
      if (pulses_left_q == CntBits'(PulsesForSync)) begin
        last_stamp_d  = stamp_q;
        pulses_left_d = pulses_left_q - 1'b1;
      end else if (pulses_left_q != '0) begin
        intervals_d[slot] = stamp_q - last_stamp_q;
        last_stamp_d      = stamp_q;
        pulses_left_d     = pulses_left_q - 1'b1;
      end else begin
        pulses_left_d   = CntBits'(PulsesForSync);
        res_d.evaluated = 1'b1;
        if (lock_ok) begin
          res_d.locked      = 1'b1;
          res_d.sync_period = intervals_q[1];
          hunt_d            = 1'b0;
        end
      end
    end
    res_d.hunting = hunt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q        <= 1'b1;
      pulses_left_q <= CntBits'(PulsesForSync);
      last_stamp_q  <= '0;
      intervals_q   <= '0;
    end else if (advance) begin
      hunt_q        <= hunt_d;
      pulses_left_q <= pulses_left_d;
      last_stamp_q  <= last_stamp_d;
      intervals_q   <= intervals_d;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.evaluated   = out_q.evaluated;
  assign out_o.locked      = out_q.locked;
  assign out_o.sync_period = out_q.sync_period;
  assign out_o.hunting     = out_q.hunting;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulses_left_q <= CntBits'(PulsesForSync))
    else $error("pulse count out of range");

  a_eval_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.evaluated) |=> (pulses_left_q == CntBits'(PulsesForSync)))
    else $error("pulse count not restarted after evaluation");

  a_lock_leaves_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.locked) |-> (out_o.evaluated && !out_o.hunting))
    else $error("locked result inconsistent");

  a_hunt_falls_on_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(hunt_q) |-> (out_valid_q && out_q.locked))
    else $error("hunting left without a lock");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty result slot");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the IR pulse period sync checker
// Drives pulse and window-missed events and register writes through the
// valid/ready channels. A scoreboard class keeps its own copy of the hunting
// state and configuration, works out the result of every event transfer and
// compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import irpsc_pkg::*;

  // Scoreboard: hunting state, register copy and the queue of pending results
  class sync_scoreboard;
    stamp_t                   imargin;
    stamp_t                   pmargin;
    stamp_t                   period[NumPeriods];
    bit                       hunt;
    logic [CntBits-1:0]       left;
    stamp_t                   last;
    stamp_t                   ivl[NumIntervals];
    logic [IdxBits-1:0]       idx;
    res_t                     pending_q[$];
    int                       errors;
    int                       results;
    int                       evals;
    int                       locks;

    function new();
      imargin   = 24'd65;
      pmargin   = 24'd32;
      period[0] = 24'd163;
      period[1] = 24'd819;
      period[2] = 24'd1638;
      period[3] = 24'd3276;
      hunt      = 1'b1;
      left      = CntBits'(PulsesForSync);
      last      = '0;
      foreach (ivl[i]) ivl[i] = '0;
      idx       = '0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] r, stamp_t v);
      case (r)
        RegIntervalMargin: imargin = v;
        RegPeriodMargin:   pmargin = v;
        RegPeriodA:        period[0] = v;
        RegPeriodB:        period[1] = v;
        RegPeriodC:        period[2] = v;
        RegPeriodD:        period[3] = v;
        default: ;
      endcase
    endfunction

    // Lower bound clamps at zero, upper bound carries into a spare bit
    function bit near(stamp_t v, stamp_t centre, stamp_t m);
      logic [StampBits:0] lo;
      logic [StampBits:0] hi;
      lo = (centre >= m) ? {1'b0, centre - m} : '0;
      hi = {1'b0, centre} + {1'b0, m};
      return ({1'b0, v} >= lo) && ({1'b0, v} <= hi);
    endfunction

    // Advance the hunting state by one event and return its result
    function res_t advance(mode_e m, stamp_t s);
      res_t r;
      bit   hit;
      bit   ok;
      r = '0;
      if (m == ModeMissed) begin
        hunt = 1'b1;
      end else if (hunt) begin
        if (left == PulsesForSync) begin
          last = s;
          left = left - 1'b1;
        end else if (left != 0) begin
          if (idx < NumIntervals) ivl[idx] = s - last;
          last = s;
          idx  = idx + 1'b1;
          left = left - 1'b1;
        end else begin
          hit = 1'b0;
          foreach (period[i]) if (near(ivl[1], period[i], pmargin)) hit = 1'b1;
          ok = near(ivl[1], ivl[0], imargin) && near(ivl[2], ivl[1], imargin) && hit;
          idx         = '0;
          left        = CntBits'(PulsesForSync);
          r.evaluated = 1'b1;
          if (ok) begin
            r.locked      = 1'b1;
            r.sync_period = ivl[1];
            hunt          = 1'b0;
          end
        end
      end
      r.hunting = hunt;
      return r;
    endfunction

    function void note_event(mode_e m, stamp_t s);
      pending_q.push_back(advance(m, s));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(res_t got);
      res_t want;
      results++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result eval=%0b lock=%0b period=%06h hunt=%0b",
                         got.evaluated, got.locked, got.sync_period, got.hunting));
        return;
      end
      want = pending_q.pop_front();
      if (got.evaluated !== want.evaluated || got.locked !== want.locked ||
          got.sync_period !== want.sync_period || got.hunting !== want.hunting) begin
        report($sformatf({"result %0d exp eval=%0b lock=%0b period=%06h hunt=%0b, ",
                          "got eval=%0b lock=%0b period=%06h hunt=%0b"},
                         results, want.evaluated, want.locked, want.sync_period, want.hunting,
                         got.evaluated, got.locked, got.sync_period, got.hunting));
      end
      if (want.evaluated) evals++;
      if (want.locked) locks++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  irpsc_in_if  in_if ();
  irpsc_out_if out_if ();
  irpsc_cfg_if cfg_if ();

  ir_pulse_period_sync_checker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  sync_scoreboard sb   = new();
  sync_scoreboard plan = new();

  bit src_calm;
  bit snk_calm;
  bit drain_next;
  int hold_cycles;
  int long_holds;
  int busy_items;
  int phases;

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watch the three channels and feed the scoreboard
  always @(posedge clk_i) begin : watch_channels
    res_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_event(mode_e'(in_if.mode), in_if.stamp);
      if (out_if.valid && out_if.ready) begin
        got.evaluated   = out_if.evaluated;
        got.locked      = out_if.locked;
        got.sync_period = out_if.sync_period;
        got.hunting     = out_if.hunting;
        sb.check_result(got);
      end
    end
  end

  // Result receiver: random stalls, occasional long hold-off
  initial begin : result_sink
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        long_holds++;
      end else begin
        if ($urandom_range(0, 29) == 0) snk_calm = !snk_calm;
        gap = snk_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Offer one event and hold it until the transfer
  task automatic offer_event(mode_e m, stamp_t s);
    int gap;
    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0 || drain_next) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_next) begin
        do @(posedge clk_i); while (sb.pending() != 0);
        drain_next = 1'b0;
      end
    end
    if (m == ModeMissed || plan.hunt) busy_items++;
    void'(plan.advance(m, s));
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.stamp <= s;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Five pulses: a start stamp, three intervals and the evaluating pulse
  task automatic send_seq(stamp_t s0, stamp_t a, stamp_t b, stamp_t c);
    offer_event(ModePulse, s0);
    offer_event(ModePulse, s0 + a);
    offer_event(ModePulse, s0 + a + b);
    offer_event(ModePulse, s0 + a + b + c);
    offer_event(ModePulse, stamp_t'($urandom));
  endtask

  // Drop valid and wait until every result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write every register index, the unused ones included
  task automatic load_config(stamp_t im, stamp_t pm, stamp_t pa, stamp_t pb,
                             stamp_t pc, stamp_t pd);
    stamp_t vals[1 << CfgIdxBits];
    foreach (vals[i]) vals[i] = stamp_t'($urandom);
    vals[RegIntervalMargin] = im;
    vals[RegPeriodMargin]   = pm;
    vals[RegPeriodA]        = pa;
    vals[RegPeriodB]        = pb;
    vals[RegPeriodC]        = pc;
    vals[RegPeriodD]        = pd;
    for (int r = 0; r < (1 << CfgIdxBits); r++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= r[CfgIdxBits-1:0];
      cfg_if.data  <= vals[r];
      do @(posedge clk_i); while (!cfg_if.ready);
      plan.write_reg(r[CfgIdxBits-1:0], vals[r]);
    end
    cfg_if.valid <= 1'b0;
    phases++;
  endtask

  // Value near centre: mostly inside the margin, sometimes just outside
  function automatic stamp_t jitter(stamp_t centre, stamp_t margin);
    int w;
    w = (margin > 1000) ? 1000 : int'(margin);
    if ($urandom_range(0, 3) == 0) w += 3;
    return centre + stamp_t'(int'($urandom_range(0, 2 * w)) - w);
  endfunction

  function automatic stamp_t pick_period();
    case ($urandom_range(0, 3))
      0:       return stamp_t'($urandom_range(0, 60));
      1:       return stamp_t'($urandom);
      2:       return '1;
      default: return stamp_t'($urandom_range(100, 5000));
    endcase
  endfunction

  // Random events: mostly full hunting sequences, some noise and broken runs
  task automatic run_random(int n);
    int     goal;
    stamp_t s0;
    stamp_t mid;
    goal = busy_items + n;
    while (busy_items < goal) begin
      if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if (!plan.hunt) offer_event(ModeMissed, stamp_t'($urandom));
          while (plan.left != PulsesForSync) offer_event(ModePulse, stamp_t'($urandom));
          s0  = ($urandom_range(0, 3) == 0) ? stamp_t'('1 - $urandom_range(0, 5000))
                                            : stamp_t'($urandom);
          mid = jitter(plan.period[$urandom_range(0, NumPeriods - 1)], plan.pmargin);
          send_seq(s0, jitter(mid, plan.imargin), mid, jitter(mid, plan.imargin));
        end
        7, 8: begin
          offer_event(($urandom_range(0, 3) == 0) ? ModeMissed : ModePulse,
                      stamp_t'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 3)) offer_event(ModePulse, stamp_t'($urandom));
          offer_event(ModeMissed, stamp_t'($urandom));
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int k;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.mode   <= ModePulse;
    in_if.stamp  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= RegIntervalMargin;
    cfg_if.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: wrap and lock, ignored pulse, missed windows, margin clamp,
    // failed evaluations and a missed window in the middle of a count
    send_seq(24'hFFFFF0, 24'd163, 24'd163, 24'd163);
    offer_event(ModePulse, 24'hFFFFFF);
    offer_event(ModeMissed, 24'hFFFFFF);
    offer_event(ModeMissed, 24'h000000);
    send_seq(24'h000000, 24'd20, 24'd30, 24'd40);
    offer_event(ModePulse, 24'd100);
    offer_event(ModePulse, 24'd919);
    offer_event(ModeMissed, 24'd0);
    offer_event(ModePulse, 24'd1738);
    offer_event(ModePulse, 24'd2557);
    offer_event(ModePulse, 24'd0);
    offer_event(ModeMissed, 24'd0);
    send_seq(24'h800000, 24'd1638, 24'd1800, 24'd1638);

    // Reset configuration: long receiver hold while the sender keeps going
    hold_cycles = 80;
    src_calm    = 1'b1;
    run_random(40);
    src_calm    = 1'b0;
    drain_next  = 1'b1;
    run_random(60);
    drain_results();

    // Zero margins, extreme periods
    load_config('0, '0, '0, '1, 24'd163, 24'd1);
    run_random(60);
    drain_results();

    // Full-scale margins
    load_config('1, '1, '1, '0, 24'hABCDEF, 24'h543210);
    run_random(60);
    drain_results();

    // Random settings
    repeat (3) begin
      load_config(stamp_t'($urandom_range(0, 300)), stamp_t'($urandom_range(0, 300)),
                  pick_period(), pick_period(), pick_period(), pick_period());
      run_random(60);
      drain_results();
    end

    in_if.valid <= 1'b0;
    for (k = 0; k < 5000 && sb.pending() != 0; k++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Checked %0d results over %0d register settings: %0d evaluations, %0d locks.",
             sb.results, phases + 1, sb.evals, sb.locks);
    $display("Receiver long holds: %0d; mismatches: %0d.", long_holds, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
